[rtl/url_percent_decoder_assert.svh]
// Assertion macros for the URL percent-decoder port checker.
// Expects signals named clk and rst_n in the scope of use.
`ifndef URL_PERCENT_DECODER_ASSERT_SVH
`define URL_PERCENT_DECODER_ASSERT_SVH

// Same-cycle implication, held off while reset is low
`define UPD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("url_percent_decoder: port check failed");

// Next-cycle implication, held off while reset is low
`define UPD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("url_percent_decoder: port check failed");

`endif

[rtl/upd_pkg.sv]
// Shared types, character codes and helper functions for the URL percent-decoder.
// No dependencies; imported by every module of the block.
package upd_pkg;

    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;

    // Bytes a single input beat can produce
    localparam int MAX_RESULTS = 3;

    typedef enum logic [1:0] {
        PEND_IDLE  = 2'd0,
        PEND_PCT   = 2'd1,
        PEND_DIGIT = 2'd2
    } upd_pend_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } upd_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } upd_out_t;

    // Decoded bytes of one input beat; last applies to the final one only
    typedef struct packed {
        logic [1:0]                  count;
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic                        last;
    } upd_burst_t;

    // Burst with its valid flag, as passed front -> queue -> back
    typedef struct packed {
        logic       valid;
        upd_burst_t burst;
    } upd_qhead_t;

    // Bit 4 set when the byte is not a hex digit, else nibble in [3:0]
    function automatic logic [4:0] hex_nibble(input logic [7:0] b);
        logic [4:0] r;
        r = 5'h10;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b0, 4'(b - 8'h30)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b0, 4'(b - 8'h37)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b0, 4'(b - 8'h57)};
        end
        return r;
    endfunction

    // Plain byte outside an escape: '+' becomes space in form mode
    function automatic logic [7:0] map_plain(input logic [7:0] b, input logic plus_mode);
        logic [7:0] r;
        r = b;
        if (b == CHAR_PLUS && plus_mode) begin
            r = CHAR_SPACE;
        end
        return r;
    endfunction

endpackage

[rtl/url_percent_decoder.sv]
// Top level of the streaming URL percent-decoder.
// Depends on upd_pkg, upd_front, upd_queue and upd_back.
//
// Takes one encoded byte per cycle unless in_stall is high; each yields zero
// to three decoded bytes. The front end classifies a beat in the cycle it is
// taken and writes its bytes as one burst into a two-entry queue; the back end
// reads a burst out one byte per cycle, unless out_stall holds it, through an
// output register, so a first byte passes the queue, then that register. The
// sustained rate is one beat per cycle if beats yield at most one byte each
// and out_stall is low; a multi-byte beat holds the back end until its bytes
// are out. in_stall rises when the queue holds two bursts. The mode register
// (plus_to_space, reset 1) is written on any cycle with cfg_valid high;
// cfg_ready is always high. Write it only while the block is idle.
module url_percent_decoder
    import upd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  upd_in_t  in_data,
    output logic     out_valid,
    input  logic     out_stall,
    output upd_out_t out_data,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  logic     cfg_data
);

    upd_qhead_t push;
    upd_qhead_t head;
    logic       q_full;
    logic       pop;

    assign cfg_ready = 1'b1;

    upd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .push      (push)
    );

    upd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (q_full),
        .head  (head)
    );

    upd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

[rtl/upd_front.sv]
// Front end: accepts input beats, tracks the escape state and builds output bursts.
// Depends on upd_pkg; holds the plus_to_space mode register.
module upd_front
    import upd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  upd_in_t    in_data,
    input  logic       cfg_valid,
    input  logic       cfg_data,
    input  logic       q_full,
    output upd_qhead_t push
);

    upd_pend_t  pend_reg, pend_next;
    logic [7:0] held_reg, held_next;
    logic       plus_mode_reg;

    logic       accept;
    logic [4:0] in_hex;
    logic [4:0] held_hex;
    logic       idle_open;
    logic [7:0] idle_out;
    upd_burst_t burst;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    // Classify the incoming byte
    always_comb
    begin
        in_hex    = hex_nibble(in_data.in_byte);
        held_hex  = hex_nibble(held_reg);
        idle_open = (in_data.in_byte == CHAR_PERCENT) && !in_data.last_byte;
        idle_out  = map_plain(in_data.in_byte, plus_mode_reg);
    end

    // Next escape state and the bytes this beat releases
    always_comb
    begin
        burst      = '0;
        burst.last = in_data.last_byte;
        pend_next  = pend_reg;
        held_next  = held_reg;
        unique case (pend_reg)
            PEND_PCT:
            begin
                if (!in_hex[4]) begin
                    if (in_data.last_byte) begin
                        burst.bytes[0] = CHAR_PERCENT;
                        burst.bytes[1] = in_data.in_byte;
                        burst.count    = 2'd2;
                        pend_next      = PEND_IDLE;
                    end else begin
                        held_next = in_data.in_byte;
                        pend_next = PEND_DIGIT;
                    end
                end else begin
                    burst.bytes[0] = CHAR_PERCENT;
                    if (idle_open) begin
                        burst.count = 2'd1;
                        pend_next   = PEND_PCT;
                    end else begin
                        burst.bytes[1] = idle_out;
                        burst.count    = 2'd2;
                        pend_next      = PEND_IDLE;
                    end
                end
            end
            PEND_DIGIT:
            begin
                if (!in_hex[4] && !held_hex[4]) begin
                    burst.bytes[0] = {held_hex[3:0], in_hex[3:0]};
                    burst.count    = 2'd1;
                    pend_next      = PEND_IDLE;
                end else begin
                    burst.bytes[0] = CHAR_PERCENT;
                    burst.bytes[1] = map_plain(held_reg, plus_mode_reg);
                    if (idle_open) begin
                        burst.count = 2'd2;
                        pend_next   = PEND_PCT;
                    end else begin
                        burst.bytes[2] = idle_out;
                        burst.count    = 2'd3;
                        pend_next      = PEND_IDLE;
                    end
                end
            end
            default:
            begin
                if (idle_open) begin
                    pend_next = PEND_PCT;
                end else begin
                    burst.bytes[0] = idle_out;
                    burst.count    = 2'd1;
                    pend_next      = PEND_IDLE;
                end
            end
        endcase
    end

    // Hand the burst of an accepted beat to the queue unless it is empty
    always_comb
    begin
        push.valid = accept && (burst.count != 2'd0);
        push.burst = burst;
    end

    // Escape state and mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pend_reg      <= PEND_IDLE;
            held_reg      <= '0;
            plus_mode_reg <= 1'b1;
        end else begin
            if (accept) begin
                pend_reg <= pend_next;
                held_reg <= held_next;
            end
            if (cfg_valid) begin
                plus_mode_reg <= cfg_data;
            end
        end
    end

endmodule

[rtl/upd_queue.sv]
// Two-entry burst queue between front and back ends of the percent-decoder.
// Depends on upd_pkg for the burst type.
module upd_queue
    import upd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  upd_qhead_t push,
    input  logic       pop,
    output logic       full,
    output upd_qhead_t head
);

    upd_burst_t mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg, fill_next;

    assign full       = (fill_reg == 2'd2);
    assign head.valid = (fill_reg != 2'd0);
    assign head.burst = mem[rd_ptr_reg];

    // Track occupancy
    always_comb
    begin
        fill_next = fill_reg;
        if (push.valid && !pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (pop && !push.valid) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    // Store pushed bursts
    always_ff @(posedge clk)
    begin
        if (push.valid) begin
            mem[wr_ptr_reg] <= push.burst;
        end
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push.valid) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            fill_reg <= fill_next;
        end
    end

endmodule

[rtl/upd_back.sv]
// Back end: unpacks queued bursts into single output beats behind an output register.
// Depends on upd_pkg for the burst and output types.
module upd_back
    import upd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  upd_qhead_t head,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output upd_out_t   out_data
);

    logic [1:0] sub_reg;
    logic       out_valid_reg;
    upd_out_t   out_data_reg;
    logic       load;
    logic       final_beat;

    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;
    assign load       = head.valid && (!out_valid_reg || !out_stall);
    assign final_beat = (sub_reg == head.burst.count - 2'd1);
    assign pop        = load && final_beat;

    // Step through the bytes of the head burst
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sub_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                sub_reg <= final_beat ? 2'd0 : sub_reg + 2'd1;
            end
            out_valid_reg <= load || (out_valid_reg && out_stall);
        end
    end

    // Hold the beat while stalled, else load the next byte
    always_ff @(posedge clk)
    begin
        if (load) begin
            out_data_reg.out_byte <= head.burst.bytes[sub_reg];
            out_data_reg.out_last <= head.burst.last && final_beat;
        end
    end

endmodule

[rtl/upd_checker.sv]
// Port-level checker for the URL percent-decoder, bound to the top level.
// Depends on upd_pkg and url_percent_decoder_assert.svh.
`include "url_percent_decoder_assert.svh"

module upd_checker
    import upd_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_stall,
    input upd_in_t  in_data,
    input logic     out_valid,
    input logic     out_stall,
    input upd_out_t out_data,
    input logic     cfg_valid,
    input logic     cfg_ready,
    input logic     cfg_data
);

    // Hold a stalled output beat
    `UPD_ASSERT_NXT(a_out_valid_hold, out_valid && out_stall, out_valid)
    `UPD_ASSERT_NXT(a_out_data_hold, out_valid && out_stall, $stable(out_data))

    // With the output register empty the queue has room
    `UPD_ASSERT_IMP(a_no_stall_when_drained, !out_valid, !in_stall)

    // A fresh output beat comes from an accepted beat, via the queue and the output register
    `UPD_ASSERT_IMP(a_out_after_accept, $rose(out_valid), $past(in_valid && !in_stall, 2))

endmodule

bind url_percent_decoder upd_checker u_checker (.*);
